// ===== rtl/dtmf_pkg.sv =====
package dtmf_pkg;

    localparam int SineDepth  = 1024;
    localparam int SineIdxW   = $clog2(SineDepth);
    localparam int PhaseW     = 32;
    localparam int RateW      = 18;
    localparam int CountW     = 24;
    localparam int IntensW    = 16;
    localparam int FreqW      = 11;
    localparam int CodeW      = 16;
    localparam int CfgAddrW   = 3;
    localparam int CfgDataW   = 24;
    localparam int QueueDepth = 2;

    localparam logic [1:0] StatusIdle    = 2'd0;
    localparam logic [1:0] StatusTone    = 2'd1;
    localparam logic [1:0] StatusSilence = 2'd2;
    localparam logic [1:0] StatusReject  = 2'd3;

    localparam logic [CfgAddrW-1:0] RegRate    = 3'd0;
    localparam logic [CfgAddrW-1:0] RegTone    = 3'd1;
    localparam logic [CfgAddrW-1:0] RegSilence = 3'd2;
    localparam logic [CfgAddrW-1:0] RegIntens  = 3'd3;
    localparam logic [CfgAddrW-1:0] RegWide    = 3'd4;
    localparam logic [CfgAddrW-1:0] RegStereo  = 3'd5;

    localparam logic [1:0] ModeIdle    = 2'd0;
    localparam logic [1:0] ModeTone    = 2'd1;
    localparam logic [1:0] ModeSilence = 2'd2;

    // classified command handed from front to back
    typedef struct packed {
        logic             start;
        logic [FreqW-1:0] row;
        logic [FreqW-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic [1:0]       status;
        logic [CodeW-1:0] left;
        logic [CodeW-1:0] right;
        logic             last;
    } t_result;

    function automatic logic [2*FreqW-1:0] key_freqs(input logic [7:0] k);
        logic [FreqW-1:0] r;
        logic [FreqW-1:0] c;
        r = '0;
        c = '0;
        unique case (k)
            8'h31: begin r = 11'd697; c = 11'd1209; end
            8'h32: begin r = 11'd697; c = 11'd1336; end
            8'h33: begin r = 11'd697; c = 11'd1477; end
            8'h41: begin r = 11'd697; c = 11'd1633; end
            8'h34: begin r = 11'd770; c = 11'd1209; end
            8'h35: begin r = 11'd770; c = 11'd1336; end
            8'h36: begin r = 11'd770; c = 11'd1477; end
            8'h42: begin r = 11'd770; c = 11'd1633; end
            8'h37: begin r = 11'd852; c = 11'd1209; end
            8'h38: begin r = 11'd852; c = 11'd1336; end
            8'h39: begin r = 11'd852; c = 11'd1477; end
            8'h43: begin r = 11'd852; c = 11'd1633; end
            8'h2A: begin r = 11'd941; c = 11'd1209; end
            8'h30: begin r = 11'd941; c = 11'd1336; end
            8'h23: begin r = 11'd941; c = 11'd1477; end
            8'h44: begin r = 11'd941; c = 11'd1633; end
            default: begin r = '0; c = '0; end
        endcase
        return {r, c};
    endfunction

    // quarter-wave polynomial sine entry, worked out at elaboration only
    function automatic logic signed [16:0] sine_entry(input int kk);
        longint unsigned q, r, t, t2, p, s, m;
        longint unsigned d;
        d = longint'(SineDepth);
        q = (4 * longint'(kk)) >> SineIdxW;
        r = 4 * longint'(kk) - q * d;
        if (q[0]) r = d - r;
        t = (r << 30) >> SineIdxW;
        t2 = (t * t) >> 30;
        p = 172272;
        p = 5026994 - ((t2 * p) >> 30);
        p = 85569305 - ((t2 * p) >> 30);
        p = 693598668 - ((t2 * p) >> 30);
        p = 1686629713 - ((t2 * p) >> 30);
        s = (t * p) >> 30;
        m = (s * 32767 + (64'd1 << 29)) >> 30;
        if (m > 32767) m = 32767;
        return (q >= 2) ? -$signed({1'b0, m[15:0]}) : $signed({1'b0, m[15:0]});
    endfunction

    typedef logic signed [16:0] t_sine_rom [SineDepth];

    function automatic t_sine_rom build_rom();
        t_sine_rom rom;
        for (int i = 0; i < SineDepth; i++) rom[i] = sine_entry(i);
        return rom;
    endfunction

    localparam t_sine_rom SineRom = build_rom();

endpackage

// ===== rtl/dtmf_front.sv =====
module dtmf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic           i_cmd,
    input  logic [7:0]     i_key_char,
    output dtmf_pkg::t_cmd o_q_data,
    output logic           o_q_valid,
    input  logic           i_q_pop
);
    import dtmf_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    t_cmd              r_mem [QueueDepth];
    logic [PtrW-1:0]   r_wr, r_rd;
    logic [PtrW:0]     r_cnt;
    logic [2*FreqW-1:0] w_f;
    logic              w_push, w_pop;

    assign w_f    = key_freqs(i_key_char);
    assign o_full = (r_cnt == (PtrW+1)'(QueueDepth));
    assign w_push = i_push && !o_full;
    assign o_q_valid = (r_cnt != '0);
    assign w_pop  = i_q_pop && o_q_valid;
    assign o_q_data = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= '{start: !i_cmd, row: w_f[2*FreqW-1:FreqW],
                                    col: w_f[FreqW-1:0]};
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (PtrW+1)'(w_push) - (PtrW+1)'(w_pop);
        end
    end
endmodule

// ===== rtl/dtmf_divider.sv =====
module dtmf_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_go,
    input  logic [dtmf_pkg::FreqW-1:0] i_num,
    input  logic [dtmf_pkg::RateW-1:0] i_den,
    output logic                      o_done,
    output logic [dtmf_pkg::PhaseW-1:0] o_quot
);
    import dtmf_pkg::*;

    // restoring division of (num << PhaseW) by den, one quotient bit a cycle
    localparam int NumW = FreqW + PhaseW;
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0]  r_num;
    logic [RateW:0]   r_rem;
    logic [NumW-1:0]  r_quo;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic [RateW:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem[RateW-1:0], r_num[NumW-1]};
    assign w_ge = w_sh >= {1'b0, i_den};
    assign o_quot = r_quo[PhaseW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_num <= {i_num, {PhaseW{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NumW-2:0], 1'b0};
            r_rem <= w_ge ? w_sh - {1'b0, i_den} : w_sh;
            r_quo <= {r_quo[NumW-2:0], w_ge};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= !i_go && r_busy && (r_cnt == CntW'(1));
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt <= CntW'(NumW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) r_busy <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/dtmf_back.sv =====
module dtmf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dtmf_pkg::t_cmd              i_q_data,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  logic [dtmf_pkg::RateW-1:0]  i_rate,
    input  logic [dtmf_pkg::CountW-1:0] i_tone,
    input  logic [dtmf_pkg::CountW-1:0] i_silence,
    input  logic [dtmf_pkg::IntensW-1:0] i_intens,
    input  logic                        i_wide,
    input  logic                        i_stereo,
    output dtmf_pkg::t_result           o_res,
    output logic                        o_res_valid,
    input  logic                        i_res_take
);
    import dtmf_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StDivLo = 3'd1;
    localparam logic [2:0] StDivHi = 3'd2;
    localparam logic [2:0] StMul   = 3'd3;
    localparam logic [2:0] StOut   = 3'd4;

    logic [2:0]          r_st;
    logic [1:0]          r_mode;
    logic [PhaseW-1:0]   r_lph, r_hph, r_lstep, r_hstep;
    logic [CountW-1:0]   r_left;
    logic [FreqW-1:0]    r_row;
    logic [FreqW-1:0]    r_col;
    logic signed [17:0]  r_sum;
    logic [33:0]         r_mag;
    t_result             r_pend;
    logic                r_tone_tick;
    logic                r_div_go;
    logic                w_div_go;
    logic                w_div_done;
    logic [PhaseW-1:0]   w_quot;
    logic [FreqW-1:0]    w_num;
    logic                w_rate0;
    logic [16:0]         w_abs;
    logic [33:0]         w_sh;
    logic signed [34:0]  w_v;
    logic [CodeW-1:0]    w_code;
    logic [CodeW-1:0]    w_quiet;
    logic [CountW-1:0]   w_dec;

    assign w_rate0 = (i_rate == '0);
    assign w_num = (r_st == StDivHi) ? r_col : r_row;
    assign w_quiet = i_wide ? 16'd0 : 16'd128;

    // first division starts after a start is taken, second after the first ends
    assign w_div_go = ((r_st == StIdle) && i_q_valid && i_q_data.start && (i_tone != '0)
                       && !w_rate0) || ((r_st == StDivLo) && w_div_done);

    dtmf_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (w_num),
        .i_den   (i_rate),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // result register: one beat waiting for the output queue
    assign o_res = r_pend;
    assign o_res_valid = (r_st == StOut) && !r_tone_tick;
    assign o_q_pop = (r_st == StIdle) && i_q_valid;
    assign w_dec = r_left - 1'b1;

    always_comb begin
        w_abs = r_sum[17] ? 17'(-r_sum) : 17'(r_sum);
        w_sh = i_wide ? (r_mag >> 15) : (r_mag >> 23);
        w_v = r_sum[17] ? -$signed({1'b0, w_sh}) : $signed({1'b0, w_sh});
        if (i_wide) begin
            if (w_v > 35'sd32767) w_code = 16'h7FFF;
            else if (w_v < -35'sd32768) w_code = 16'h8000;
            else w_code = w_v[15:0];
        end else begin
            // offset binary: adding 128 flips the sign bit
            if (w_v > 35'sd127) w_code = 16'd255;
            else if (w_v < -35'sd128) w_code = 16'd0;
            else w_code = {8'd0, ~w_v[7], w_v[6:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_mode <= ModeIdle;
            r_lph <= '0;
            r_hph <= '0;
            r_lstep <= '0;
            r_hstep <= '0;
            r_left <= '0;
            r_div_go <= 1'b0;
            r_tone_tick <= 1'b0;
        end else begin
            r_div_go <= w_div_go;
            unique case (r_st)
                StIdle: if (i_q_valid) begin
                    r_tone_tick <= !i_q_data.start && (r_mode == ModeTone);
                    if (i_q_data.start) begin
                        r_row <= i_q_data.row;
                        r_col <= i_q_data.col;
                        if (i_tone == '0) begin
                            r_mode <= ModeIdle;
                            r_left <= '0;
                            r_pend <= '{status: StatusReject, left: '0, right: '0,
                                        last: 1'b0};
                            r_st <= StOut;
                        end else begin
                            r_pend <= '{status: StatusIdle, left: '0, right: '0,
                                        last: 1'b0};
                            r_lph <= '0;
                            r_hph <= '0;
                            r_left <= i_tone;
                            r_mode <= ModeTone;
                            if (w_rate0) begin
                                r_lstep <= '0;
                                r_hstep <= '0;
                                r_st <= StOut;
                            end else begin
                                r_st <= StDivLo;
                            end
                        end
                    end else if (r_mode == ModeTone) begin
                        r_sum <= 18'(SineRom[r_lph[PhaseW-1 -: SineIdxW]])
                               + 18'(SineRom[r_hph[PhaseW-1 -: SineIdxW]]);
                        r_lph <= r_lph + r_lstep;
                        r_hph <= r_hph + r_hstep;
                        r_pend <= '{status: StatusTone, left: '0, right: '0,
                                    last: (w_dec == '0) && (i_silence == '0)};
                        r_left <= ((w_dec == '0) && (i_silence != '0)) ? i_silence : w_dec;
                        if (w_dec == '0) r_mode <= (i_silence != '0) ? ModeSilence : ModeIdle;
                        r_st <= StMul;
                    end else if (r_mode == ModeSilence) begin
                        r_pend <= '{status: StatusSilence, left: w_quiet,
                                    right: i_stereo ? w_quiet : 16'd0,
                                    last: (w_dec == '0)};
                        r_left <= w_dec;
                        if (w_dec == '0) r_mode <= ModeIdle;
                        r_st <= StOut;
                    end else begin
                        r_pend <= '{status: StatusIdle, left: '0, right: '0, last: 1'b0};
                        r_mode <= ModeIdle;
                        r_st <= StOut;
                    end
                end
                StDivLo: if (w_div_done) begin
                    r_lstep <= w_quot;
                    r_st <= StDivHi;
                end
                StDivHi: if (w_div_done) begin
                    r_hstep <= w_quot;
                    r_st <= StOut;
                end
                StMul: begin
                    r_mag <= 34'(w_abs) * 34'(i_intens);
                    r_st <= StOut;
                    r_tone_tick <= 1'b1;
                end
                StOut: begin
                    if (r_tone_tick) begin
                        r_pend.left <= w_code;
                        r_pend.right <= i_stereo ? w_code : '0;
                        r_tone_tick <= 1'b0;
                    end else if (i_res_take) begin
                        r_st <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule

// ===== rtl/dtmf_sample_generator.sv =====
// dtmf sample generator
// input queue: push a beat (i_cmd, i_key_char) while full is low. cmd 0
// starts a key (row/column tones from the key character, unknown keys are
// silent tones), cmd 1 asks for one audio sample tick
// result queue: while empty is low the oldest result beat is on o_status,
// o_left_code, o_right_code and o_last; pop takes it
// config: i_cfg_we writes i_cfg_data into register i_cfg_addr (0 rate,
// 1 tone length, 2 silence length, 3 intensity, 4 wide samples, 5 stereo)
// a front part decodes the key into a two-entry command queue; the back part
// runs one command at a time. a start runs two 43-step restoring divisions
// of f*2^32 by the sample rate, one quotient bit a cycle, and skips them
// with a zero rate. a tone tick goes through table read, multiply, encode
// and output register, in that order
// reset clears the generator to idle and reloads the register defaults;
// a stalled result queue holds the back part, and the front part keeps
// taking beats until its queue fills, then raises full
module dtmf_sample_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [7:0]  i_key_char,
    output logic        empty,
    input  logic        pop,
    input  logic        i_cfg_we,
    input  logic [dtmf_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [dtmf_pkg::CfgDataW-1:0] i_cfg_data,
    output logic [1:0]  o_status,
    output logic [15:0] o_left_code,
    output logic [15:0] o_right_code,
    output logic        o_last
);
    import dtmf_pkg::*;

    logic [RateW-1:0]   r_rate;
    logic [CountW-1:0]  r_tone, r_silence;
    logic [IntensW-1:0] r_intens;
    logic               r_wide, r_stereo;
    t_cmd               w_q_data;
    logic               w_q_valid, w_q_pop;
    t_result            w_res, r_out;
    logic               w_res_valid, w_take, r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RateW'(8000);
            r_tone <= CountW'(800);
            r_silence <= CountW'(800);
            r_intens <= IntensW'(16384);
            r_wide <= 1'b1;
            r_stereo <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegRate:    r_rate <= i_cfg_data[RateW-1:0];
                RegTone:    r_tone <= i_cfg_data[CountW-1:0];
                RegSilence: r_silence <= i_cfg_data[CountW-1:0];
                RegIntens:  r_intens <= i_cfg_data[IntensW-1:0];
                RegWide:    r_wide <= i_cfg_data[0];
                RegStereo:  r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    dtmf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_cmd      (i_cmd),
        .i_key_char (i_key_char),
        .o_q_data   (w_q_data),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop)
    );

    dtmf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_q_data),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_rate      (r_rate),
        .i_tone      (r_tone),
        .i_silence   (r_silence),
        .i_intens    (r_intens),
        .i_wide      (r_wide),
        .i_stereo    (r_stereo),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_take  (w_take)
    );

    // single output register; back part moves a beat in once it is free
    assign w_take = w_res_valid && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (w_take) r_out <= w_res;
        if (!i_rst_n) r_out_valid <= 1'b0;
        else if (w_take) r_out_valid <= 1'b1;
        else if (pop) r_out_valid <= 1'b0;
    end

    assign empty = !r_out_valid;
    assign o_status = r_out.status;
    assign o_left_code = r_out.left;
    assign o_right_code = r_out.right;
    assign o_last = r_out.last;

    // a rejected start never carries sample data
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == StatusReject) |-> (o_left_code == '0 && !o_last))
        else $error("rejected start carries data");

    // right channel is zero in mono
    a_mono_right: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !r_stereo && $stable(r_stereo)) |-> (o_right_code == '0))
        else $error("right channel not zero in mono");

    // the result register only changes when it is free or being taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(!empty) && !$past(pop)) |-> $stable(o_status))
        else $error("result changed while waiting");

endmodule
